// ===== hw/rtl/srsg_pkg.sv =====
`default_nettype none

package srsg_pkg;

    // Field widths.
    localparam int SPEED_W = 24;
    localparam int TARGET_W = 25;
    localparam int TIME_W = 32;
    localparam int TOP_W = 16;
    localparam int HALF_W = 19;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;

    // The divider computes HALF_SECOND_US / (speed >> 8).
    localparam int DIVISOR_W = SPEED_W - 8;
    localparam int QUO_W = HALF_W;
    localparam int DIV_CNT_W = $clog2(QUO_W);
    localparam logic [HALF_W-1:0] HALF_SECOND_US = HALF_W'(500000);

    // Configuration reset values.
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = SPEED_W'(1024000);
    localparam logic [SPEED_W-1:0] MIN_SPEED_RST = SPEED_W'(256);
    localparam logic [SPEED_W-1:0] ACCEL_RST = SPEED_W'(256);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_SERVICE = 2'd0,
        KIND_TARGET  = 2'd1,
        KIND_TOP     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RAMP,
        S_SPEED,
        S_DIV,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/srsg_if.sv =====
`default_nettype none

// Input item channel.
interface srsg_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [srsg_pkg::KIND_W-1:0]            kind;
    logic [srsg_pkg::TIME_W-1:0]            now_us;
    logic signed [srsg_pkg::TARGET_W-1:0]   target_speed;
    logic [srsg_pkg::TOP_W-1:0]             top_value;

    modport source (output valid, kind, now_us, target_speed, top_value, input ready);
    modport sink (input valid, kind, now_us, target_speed, top_value, output ready);
endinterface

// Result channel.
interface srsg_out_if;
    logic                           valid;
    logic                           ready;
    logic                           step_out;
    logic                           driver_on;
    logic [srsg_pkg::SPEED_W-1:0]   speed_now;
    logic [srsg_pkg::HALF_W-1:0]    half_period_us;

    modport source (output valid, step_out, driver_on, speed_now, half_period_us,
                    input ready);
    modport sink (input valid, step_out, driver_on, speed_now, half_period_us,
                  output ready);
endinterface

// Configuration write channel.
interface srsg_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [srsg_pkg::CFG_IDX_W-1:0]     index;
    logic [srsg_pkg::SPEED_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srsg_div.sv =====
`default_nettype none

// Restoring divider of the fixed half-second constant by a 16-bit speed,
// one quotient bit per cycle.
module srsg_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire srsg_pkg::t_div_req i_req,
    output srsg_pkg::t_div_rsp      o_rsp
);

    localparam logic [srsg_pkg::DIV_CNT_W-1:0] LAST_STEP =
        srsg_pkg::DIV_CNT_W'(srsg_pkg::QUO_W - 1);

    logic                                r_busy, n_busy;
    logic                                r_done, n_done;
    logic [srsg_pkg::DIV_CNT_W-1:0]      r_cnt, n_cnt;
    logic [srsg_pkg::DIVISOR_W-1:0]      r_rem, n_rem;
    logic [srsg_pkg::DIVISOR_W-1:0]      r_divisor, n_divisor;
    logic [srsg_pkg::QUO_W-1:0]          r_quo, n_quo;
    logic [srsg_pkg::DIVISOR_W:0]        w_trial;
    logic [srsg_pkg::DIVISOR_W:0]        w_diff;
    logic                                w_fits;

    always_comb begin
        w_trial = {r_rem, r_quo[srsg_pkg::QUO_W-1]};
        w_diff = w_trial - {1'b0, r_divisor};
        w_fits = w_trial >= {1'b0, r_divisor};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_divisor = r_divisor;
        n_quo = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt = '0;
            n_rem = '0;
            n_divisor = i_req.divisor;
            n_quo = srsg_pkg::HALF_SECOND_US;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor, so 16 bits hold it.
            n_rem = w_fits ? w_diff[srsg_pkg::DIVISOR_W-1:0]
                           : w_trial[srsg_pkg::DIVISOR_W-1:0];
            n_quo = {r_quo[srsg_pkg::QUO_W-2:0], w_fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_divisor <= n_divisor;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/stepper_ramp_step_generator_core.sv =====
`default_nettype none

// Stepper step generator with a linear speed ramp.
// Items arrive on i_in as valid/ready transactions. Kind service carries a
// microsecond timestamp: the step level toggles once the half period has
// elapsed, the speed ramps toward the goal, and the half period is refreshed
// as 500000 / integer speed, or zeroed below the minimum or at integer speed zero.
// Kind set-target clamps and stores the goal speed; kind set-top sets the half period
// to (top + 1) / 2. Each item yields exactly one result transaction on o_out with
// the step level, driver enable, current speed and half period after the item.
// Set-target, set-top and unused kinds go from S_EXEC straight to S_PUSH; a
// service item passes S_EXEC, S_RAMP and S_SPEED, then S_DIV when a division
// runs, before S_PUSH. The serial divider makes one quotient bit per cycle over
// 19 bits. One item is in flight at a time; i_in.ready is high only in
// the idle state, so the next item can be taken as the previous result appears.
// A finished result sits in an output register, so a new item is accepted
// while the receiver stalls; the following result waits until that register
// has been taken. Configuration writes on i_cfg are always accepted.
// Reset (synchronous, active low) clears speeds, step level, timestamp and
// half period, disables the driver, and loads the configuration defaults.
module stepper_ramp_step_generator_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    srsg_in_if.sink     i_in,
    srsg_out_if.source  o_out,
    srsg_cfg_if.sink    i_cfg
);

    // Configuration registers.
    logic [srsg_pkg::SPEED_W-1:0] r_max_speed;
    logic [srsg_pkg::SPEED_W-1:0] r_min_speed;
    logic [srsg_pkg::SPEED_W-1:0] r_accel;

    // Sequencer and captured item.
    srsg_pkg::t_state                      r_state, n_state;
    logic [srsg_pkg::KIND_W-1:0]           r_kind, n_kind;
    logic [srsg_pkg::TIME_W-1:0]           r_now, n_now;
    logic signed [srsg_pkg::TARGET_W-1:0]  r_target, n_target;
    logic [srsg_pkg::TOP_W-1:0]            r_top, n_top;

    // Architectural state.
    logic [srsg_pkg::SPEED_W-1:0] r_goal, n_goal;
    logic [srsg_pkg::SPEED_W-1:0] r_ramp, n_ramp;
    logic [srsg_pkg::HALF_W-1:0]  r_half, n_half;
    logic                         r_pin, n_pin;
    logic [srsg_pkg::TIME_W-1:0]  r_last, n_last;
    logic                         r_enabled, n_enabled;

    // Output register.
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_step, n_out_step;
    logic                         r_out_drv, n_out_drv;
    logic [srsg_pkg::SPEED_W-1:0] r_out_speed, n_out_speed;
    logic [srsg_pkg::HALF_W-1:0]  r_out_half, n_out_half;

    // Serial divider instance.
    srsg_pkg::t_div_req w_div_req;
    srsg_pkg::t_div_rsp w_div_rsp;

    logic                           w_in_fire;
    logic                           w_out_free;
    logic [srsg_pkg::TIME_W-1:0]    w_elapsed;
    logic                           w_toggle;
    logic [srsg_pkg::SPEED_W:0]     w_sum;
    logic [srsg_pkg::SPEED_W-1:0]   w_gap;
    logic [srsg_pkg::SPEED_W-1:0]   w_ramp_next;
    logic [srsg_pkg::TOP_W:0]       w_top_half;
    logic [srsg_pkg::DIVISOR_W-1:0] w_whole;
    logic                           w_below_min;
    logic                           w_div_go;

    assign i_in.ready = (r_state == srsg_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire = i_in.valid && (r_state == srsg_pkg::S_IDLE);
    // The output slot can take a new result when empty or being drained now.
    assign w_out_free = !r_out_valid || o_out.ready;

    // Configuration writes; an index beyond the register list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= srsg_pkg::MAX_SPEED_RST;
            r_min_speed <= srsg_pkg::MIN_SPEED_RST;
            r_accel <= srsg_pkg::ACCEL_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                srsg_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg.data;
                srsg_pkg::REG_MIN_SPEED: r_min_speed <= i_cfg.data;
                srsg_pkg::REG_ACCEL: r_accel <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Toggle test: the wrapped elapsed time against the half period.
    always_comb begin
        w_elapsed = r_now - r_last;
        w_toggle = (r_half != '0) &&
                   (w_elapsed >= {{(srsg_pkg::TIME_W - srsg_pkg::HALF_W){1'b0}}, r_half});
    end

    // Ramp one step toward the goal without passing it. A zero acceleration
    // means the speed jumps straight to the goal.
    always_comb begin
        w_sum = {1'b0, r_ramp} + {1'b0, r_accel};
        w_gap = r_ramp - r_goal;
        w_ramp_next = r_ramp;
        if (r_accel == '0) begin
            w_ramp_next = r_goal;
        end else if (r_ramp < r_goal) begin
            w_ramp_next = (w_sum > {1'b0, r_goal}) ? r_goal
                                                   : w_sum[srsg_pkg::SPEED_W-1:0];
        end else if (r_ramp > r_goal) begin
            w_ramp_next = (w_gap <= r_accel) ? r_goal : (r_ramp - r_accel);
        end
    end

    // A zero top also yields a zero half period here, since (0 + 1) / 2 = 0.
    assign w_top_half = ({1'b0, r_top} + 1'b1) >> 1;

    // Speed check, done on the freshly ramped speed.
    always_comb begin
        w_whole = r_ramp[srsg_pkg::SPEED_W-1:8];
        w_below_min = r_ramp < r_min_speed;
        w_div_go = !w_below_min && (w_whole != '0);
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srsg_pkg::S_IDLE: begin
                if (w_in_fire) n_state = srsg_pkg::S_EXEC;
            end
            srsg_pkg::S_EXEC: begin
                n_state = (r_kind == srsg_pkg::KIND_SERVICE) ? srsg_pkg::S_RAMP
                                                              : srsg_pkg::S_PUSH;
            end
            srsg_pkg::S_RAMP: n_state = srsg_pkg::S_SPEED;
            srsg_pkg::S_SPEED: begin
                n_state = w_div_go ? srsg_pkg::S_DIV : srsg_pkg::S_PUSH;
            end
            srsg_pkg::S_DIV: begin
                if (w_div_rsp.done) n_state = srsg_pkg::S_PUSH;
            end
            srsg_pkg::S_PUSH: begin
                if (w_out_free) n_state = srsg_pkg::S_IDLE;
            end
            default: n_state = srsg_pkg::S_IDLE;
        endcase
    end

    // Datapath and output updates per state.
    always_comb begin
        n_kind = r_kind;
        n_now = r_now;
        n_target = r_target;
        n_top = r_top;
        n_goal = r_goal;
        n_ramp = r_ramp;
        n_half = r_half;
        n_pin = r_pin;
        n_last = r_last;
        n_enabled = r_enabled;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_step = r_out_step;
        n_out_drv = r_out_drv;
        n_out_speed = r_out_speed;
        n_out_half = r_out_half;
        w_div_req.start = 1'b0;
        w_div_req.divisor = w_whole;

        unique case (r_state)
            srsg_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_kind = i_in.kind;
                    n_now = i_in.now_us;
                    n_target = i_in.target_speed;
                    n_top = i_in.top_value;
                end
            end
            srsg_pkg::S_EXEC: begin
                case (r_kind)
                    srsg_pkg::KIND_SERVICE: begin
                        if (w_toggle) begin
                            n_last = r_now;
                            n_pin = !r_pin;
                        end
                    end
                    srsg_pkg::KIND_TARGET: begin
                        // Negative requests stop; large ones clamp to the maximum.
                        if (r_target[srsg_pkg::TARGET_W-1]) begin
                            n_goal = '0;
                        end else if (r_target[srsg_pkg::SPEED_W-1:0] > r_max_speed) begin
                            n_goal = r_max_speed;
                        end else begin
                            n_goal = r_target[srsg_pkg::SPEED_W-1:0];
                        end
                    end
                    srsg_pkg::KIND_TOP: begin
                        n_enabled = (r_top != '0);
                        n_half = srsg_pkg::HALF_W'(w_top_half);
                    end
                    default: ;
                endcase
            end
            srsg_pkg::S_RAMP: n_ramp = w_ramp_next;
            srsg_pkg::S_SPEED: begin
                // Below the minimum the driver sleeps. An integer speed of zero
                // keeps the driver awake but produces no pulses.
                n_enabled = !w_below_min;
                if (!w_div_go) n_half = '0;
                w_div_req.start = w_div_go;
            end
            srsg_pkg::S_DIV: begin
                if (w_div_rsp.done) n_half = w_div_rsp.quotient;
            end
            srsg_pkg::S_PUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_step = r_pin;
                    n_out_drv = r_enabled;
                    n_out_speed = r_ramp;
                    n_out_half = r_half;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srsg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_goal <= '0;
            r_ramp <= '0;
            r_half <= '0;
            r_pin <= 1'b0;
            r_last <= '0;
            r_enabled <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_goal <= n_goal;
            r_ramp <= n_ramp;
            r_half <= n_half;
            r_pin <= n_pin;
            r_last <= n_last;
            r_enabled <= n_enabled;
        end
        r_kind <= n_kind;
        r_now <= n_now;
        r_target <= n_target;
        r_top <= n_top;
        r_out_step <= n_out_step;
        r_out_drv <= n_out_drv;
        r_out_speed <= n_out_speed;
        r_out_half <= n_out_half;
    end

    srsg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_out.valid = r_out_valid;
    assign o_out.step_out = r_out_step;
    assign o_out.driver_on = r_out_drv;
    assign o_out.speed_now = r_out_speed;
    assign o_out.half_period_us = r_out_half;

    // A sleeping driver never has a running half period.
    a_off_no_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enabled |-> (r_half == '0))
        else $error("driver disabled with nonzero half period");

    // The half period never exceeds half a second.
    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half <= srsg_pkg::HALF_SECOND_US)
        else $error("half period out of range");

    // A division result arrives only while the sequencer waits for it.
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == srsg_pkg::S_DIV))
        else $error("divider finished outside the wait state");

    // An accepted item always leaves the idle state at the next edge.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == srsg_pkg::S_EXEC))
        else $error("accepted item not taken up");

endmodule

`default_nettype wire
